/* rtl/depth_tested_line_raster_unit_defines.svh */
// ----------------------------------------------------------------------------
// depth_tested_line_raster_unit_defines
// Assertion macros for the depth tested line raster unit.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TESTED_LINE_RASTER_UNIT_DEFINES_SVH
`define DEPTH_TESTED_LINE_RASTER_UNIT_DEFINES_SVH

// Assert that prop holds at every clock edge outside reset.
`define DTLR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that cond implies prop in the next cycle.
`define DTLR_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

/* rtl/dtlr_pkg.sv */
// ----------------------------------------------------------------------------
// dtlr_pkg
// Shared widths and constants for the depth tested line raster unit.
// ----------------------------------------------------------------------------
package dtlr_pkg;
   localparam int CoordW      = 6;
   localparam int DepthW      = 16;
   localparam int FracW       = 16;
   localparam int AccW        = 34;
   localparam int DivW        = 33;
   localparam int MaxResults  = 64;
   localparam int ViewWidthDefault  = 64;
   localparam int ViewHeightDefault = 64;
   localparam logic [DepthW-1:0] FarDepth = 16'hFFFF;
endpackage

/* rtl/depth_tested_line_raster_unit.sv */
// ----------------------------------------------------------------------------
// depth_tested_line_raster_unit
// Bresenham line walk with per-pixel depth test against an on-chip depth store.
// ----------------------------------------------------------------------------
// Usage: a command enters on req_ (valid/ready). func 0 draws a line from
// (x_start,y_start) to (x_end,y_end), interpolating depth from z_start to
// z_end; each visited pixel gives one item on rsp_ with its depth, whether it
// passed the depth test and updated the store, and last on the final pixel.
// func 1 clears the depth store to far and gives no item.
// One command is worked at a time. A draw first runs the serial
// depth-increment divider (one quotient bit a cycle), then walks each pixel
// through the store read (ST_READ), the depth test and write-back through
// the memory port (ST_TEST) and the output step (ST_OUT). A clear sweeps one
// entry a cycle over all VIEW_WIDTH*VIEW_HEIGHT entries. After reset the same
// clearing pass runs and req_ready stays low until it ends.
// A stalled receiver holds the result register; the walk waits for it.
// ----------------------------------------------------------------------------
`include "depth_tested_line_raster_unit_defines.svh"
module depth_tested_line_raster_unit #(
   parameter int VIEW_WIDTH  = dtlr_pkg::ViewWidthDefault,
   parameter int VIEW_HEIGHT = dtlr_pkg::ViewHeightDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic [dtlr_pkg::CoordW-1:0]     req_x_start,
   input  logic [dtlr_pkg::CoordW-1:0]     req_y_start,
   input  logic [dtlr_pkg::CoordW-1:0]     req_x_end,
   input  logic [dtlr_pkg::CoordW-1:0]     req_y_end,
   input  logic [dtlr_pkg::DepthW-1:0]     req_z_start,
   input  logic [dtlr_pkg::DepthW-1:0]     req_z_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dtlr_pkg::CoordW-1:0]     rsp_pix_x,
   output logic [dtlr_pkg::CoordW-1:0]     rsp_pix_y,
   output logic [dtlr_pkg::DepthW-1:0]     rsp_pix_depth,
   output logic                            rsp_written,
   output logic                            rsp_last
);
   import dtlr_pkg::*;

   localparam int Entries = VIEW_WIDTH * VIEW_HEIGHT;
   localparam int AddrW   = $clog2(Entries);
   localparam int XW      = $clog2(VIEW_WIDTH);
   localparam int YW      = $clog2(VIEW_HEIGHT);
   localparam int DivCnt  = DivW + 1;
   localparam int CntW    = $clog2(DivCnt + 1);
   localparam logic [CoordW-1:0] XMax = CoordW'(VIEW_WIDTH - 1);
   localparam logic [CoordW-1:0] YMax = CoordW'(VIEW_HEIGHT - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_READ, ST_TEST, ST_OUT
   } state_type;

   state_type                state_ff;
   logic [AddrW:0]           clr_ff;
   logic [CoordW-1:0]        x_ff, y_ff, x1_ff, y1_ff;
   logic [CoordW:0]          dx_ff, dy_ff;
   logic                     sx_ff, sy_ff;
   logic signed [CoordW+1:0] err_ff;
   logic [CoordW-1:0]        n_ff;
   logic signed [AccW-1:0]   acc_ff, inc_ff;
   logic [DivW-1:0]          quo_ff, num_ff;
   logic [CoordW+1:0]        rem_ff;
   logic                     neg_ff;
   logic [CntW-1:0]          cnt_ff;
   logic [DepthW-1:0]        mem [Entries];
   logic [DepthW-1:0]        rd_ff;

   logic                     out_valid_ff;
   logic [CoordW-1:0]        out_x_ff, out_y_ff;
   logic [DepthW-1:0]        out_d_ff;
   logic                     out_w_ff, out_last_ff;

   logic [CoordW-1:0]        cx0, cy0, cx1, cy1;
   logic [CoordW:0]          dsum;
   logic [DepthW-1:0]        depth;
   logic                     pass, done;
   logic [AddrW-1:0]         addr;
   logic [CoordW+2:0]        rem_sh;
   logic signed [CoordW+1:0] e2;
   logic                     step_x, step_y;
   logic signed [AccW-1:0]   acc_n;
   logic signed [CoordW+1:0] err_n;

   function automatic logic [CoordW-1:0] clampc(input logic [CoordW-1:0] v,
                                                input logic [CoordW-1:0] m);
      return (v > m) ? m : v;
   endfunction

   assign cx0  = clampc(req_x_start, XMax);
   assign cy0  = clampc(req_y_start, YMax);
   assign cx1  = clampc(req_x_end, XMax);
   assign cy1  = clampc(req_y_end, YMax);
   assign dsum = dx_ff + dy_ff;

   always_comb begin
      if (acc_ff < 0) begin
         depth = '0;
      end else if (acc_ff[AccW-1:FracW+DepthW] != '0) begin
         depth = FarDepth;
      end else begin
         depth = acc_ff[FracW+DepthW-1:FracW];
      end
   end

   assign addr = AddrW'((YW'(VIEW_HEIGHT - 1) - y_ff[YW-1:0]) * VIEW_WIDTH)
               + AddrW'(x_ff[XW-1:0]);
   assign pass = depth <= rd_ff;
   assign done = ((x_ff == x1_ff) && (y_ff == y1_ff)) || (n_ff == CoordW'(MaxResults - 1));
   assign rem_sh = {rem_ff, num_ff[DivW-1]};
   assign e2 = err_ff;
   assign step_x = e2 > -$signed({1'b0, dx_ff});
   assign step_y = e2 < $signed({1'b0, dy_ff});

   always_comb begin
      acc_n = acc_ff;
      err_n = err_ff;
      if (step_x) begin
         acc_n = acc_n + inc_ff;
         err_n = err_n - $signed({1'b0, dy_ff});
      end
      if (step_y) begin
         acc_n = acc_n + inc_ff;
         err_n = err_n + $signed({1'b0, dx_ff});
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         mem[clr_ff[AddrW-1:0]] <= FarDepth;
      end else if (state_ff == ST_TEST && pass) begin
         mem[addr] <= depth;
      end
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_TEST && (!out_valid_ff || rsp_ready)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AddrW+1)'(Entries - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  clr_ff <= '0;
                  if (req_func) begin
                     state_ff <= ST_CLEAR;
                  end else begin
                     x_ff   <= cx0;
                     y_ff   <= cy0;
                     x1_ff  <= cx1;
                     y1_ff  <= cy1;
                     dx_ff  <= (cx1 > cx0) ? {1'b0, cx1 - cx0} : {1'b0, cx0 - cx1};
                     dy_ff  <= (cy1 > cy0) ? {1'b0, cy1 - cy0} : {1'b0, cy0 - cy1};
                     sx_ff  <= cx0 < cx1;
                     sy_ff  <= cy0 < cy1;
                     n_ff   <= '0;
                     acc_ff <= AccW'({req_z_start, FracW'(0)});
                     neg_ff <= req_z_end < req_z_start;
                     num_ff <= (req_z_end < req_z_start)
                        ? DivW'({req_z_start - req_z_end, FracW'(0)})
                        : DivW'({req_z_end - req_z_start, FracW'(0)});
                     rem_ff <= '0;
                     quo_ff <= '0;
                     cnt_ff <= '0;
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (cnt_ff == CntW'(0)) begin
                  err_ff <= (dx_ff > dy_ff) ? $signed({2'b0, dx_ff[CoordW:1]})
                                            : -$signed({2'b0, dy_ff[CoordW:1]});
               end
               if (cnt_ff == CntW'(DivCnt - 1)) begin
                  if (dsum == '0) inc_ff <= '0;
                  else inc_ff <= neg_ff ? -$signed(AccW'(quo_ff)) : $signed(AccW'(quo_ff));
                  state_ff <= ST_READ;
               end else begin
                  if (rem_sh >= {2'b0, dsum}) begin
                     rem_ff <= (CoordW+2)'(rem_sh - {2'b0, dsum});
                     quo_ff <= {quo_ff[DivW-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh[CoordW+1:0];
                     quo_ff <= {quo_ff[DivW-2:0], 1'b0};
                  end
                  num_ff <= {num_ff[DivW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
            end
            ST_READ: state_ff <= ST_TEST;
            ST_TEST: begin
               if (!out_valid_ff || rsp_ready) begin
                  out_x_ff     <= x_ff;
                  out_y_ff     <= y_ff;
                  out_d_ff     <= depth;
                  out_w_ff     <= pass;
                  out_last_ff  <= done;
                  state_ff     <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_last_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  n_ff   <= n_ff + 1'b1;
                  acc_ff <= acc_n;
                  err_ff <= err_n;
                  if (step_x) x_ff <= sx_ff ? x_ff + 1'b1 : x_ff - 1'b1;
                  if (step_y) y_ff <= sy_ff ? y_ff + 1'b1 : y_ff - 1'b1;
                  state_ff <= ST_READ;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pix_x     = out_x_ff;
   assign rsp_pix_y     = out_y_ff;
   assign rsp_pix_depth = out_d_ff;
   assign rsp_written   = out_w_ff;
   assign rsp_last      = out_last_ff;

   `DTLR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_pix_x, rsp_pix_y, rsp_pix_depth}), "result dropped")
   `DTLR_ASSERT(a_no_ready_busy, clock, reset, !(req_ready && state_ff == ST_CLEAR), "ready in clear")
   `DTLR_ASSERT_NEXT(a_test_out, clock, reset, state_ff == ST_TEST && (!out_valid_ff || rsp_ready), rsp_valid, "result lost")
   `DTLR_ASSERT(a_coord_range, clock, reset, x_ff <= XMax || state_ff == ST_IDLE || state_ff == ST_CLEAR, "x range")
endmodule
